/* rtl/salru_pkg.sv */
// shared types and constants of the set-associative lru read cache
package salru_pkg;

	localparam int ADDR_W      = 9;
	localparam int SIZE_W      = 2;
	localparam int WORD_W      = 32;
	localparam int LINE_W      = 64;
	localparam int OFFSET_W    = 3;
	localparam int BLOCK_NUM_W = ADDR_W - OFFSET_W;
	localparam int STAMP_W     = 32;
	localparam int MEM_IDX_W   = 7;
	localparam int BYTE_CNT_W  = 3;
	localparam int LINE_BYTES  = 8;

	typedef enum logic {
		CMD_ACCESS = 1'b0,
		CMD_LOAD   = 1'b1
	} command_t;

	typedef enum logic [SIZE_W-1:0] {
		SIZE_BYTE = 2'd0,
		SIZE_HALF = 2'd1,
		SIZE_WORD = 2'd2
	} access_size_t;

	typedef struct packed {
		logic hit;
		logic cross_error;
	} lookup_status_t;

endpackage

/* rtl/set_assoc_cache_lru_read.sv */
// top level of the set-associative read cache with lru replacement
// flow: an accepted access reads its set row and both fill words into registers (stage one); compare,
//   fill and stamp write-back then load the result register once a stalled response no longer holds it
// requests: none is taken while an access waits in stage one (row read-modify-write); one load per cycle otherwise
// reset: clears valid bits, the access clock and both handshakes at once; the row memory
//   and the backing memory hold no reset and need no clearing pass
module set_assoc_cache_lru_read import salru_pkg::*; #(
	parameter int WAYS         = 2,
	parameter int TOTAL_BLOCKS = 4,
	parameter int MEMORY_WORDS = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                command,
	input  logic [ADDR_W-1:0]   byte_address,
	input  logic [SIZE_W-1:0]   access_size,
	input  logic [MEM_IDX_W-1:0] mem_word_index,
	input  logic [WORD_W-1:0]   mem_word_value,
	// response channel
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [WORD_W-1:0]   read_data,
	output logic                hit,
	output logic                cross_error
);

	// geometry
	localparam int NUM_SETS  = TOTAL_BLOCKS / WAYS;
	localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int MAX_TAG   = ((1 << BLOCK_NUM_W) - 1) / NUM_SETS;
	localparam int TAG_W     = (MAX_TAG > 0) ? $clog2(MAX_TAG + 1) : 1;
	localparam int ROW_W     = WAYS * (TAG_W + STAMP_W + LINE_W);
	localparam int NUM_BLOCK = 1 << BLOCK_NUM_W;
	localparam int NUM_IDX   = 1 << MEM_IDX_W;
	// only word indices below 128 are ever reachable
	localparam int MEM_DEPTH = (MEMORY_WORDS < NUM_IDX) ? MEMORY_WORDS : NUM_IDX;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	typedef logic [NUM_BLOCK-1:0][SET_W-1:0]  set_tbl_t;
	typedef logic [NUM_BLOCK-1:0][TAG_W-1:0]  tag_tbl_t;
	typedef logic [NUM_IDX-1:0][MEM_AW-1:0]   mem_tbl_t;

	// block number to set and tag, word index wrap; all built at elaboration
	function automatic set_tbl_t build_set_tbl();
		set_tbl_t t;
		for (int b = 0; b < NUM_BLOCK; b++) begin
			t[b] = SET_W'(b % NUM_SETS);
		end
		return t;
	endfunction

	function automatic tag_tbl_t build_tag_tbl();
		tag_tbl_t t;
		for (int b = 0; b < NUM_BLOCK; b++) begin
			t[b] = TAG_W'(b / NUM_SETS);
		end
		return t;
	endfunction

	function automatic mem_tbl_t build_mem_tbl();
		mem_tbl_t t;
		for (int i = 0; i < NUM_IDX; i++) begin
			t[i] = MEM_AW'(i % MEM_DEPTH);
		end
		return t;
	endfunction

	localparam set_tbl_t SET_TBL = build_set_tbl();
	localparam tag_tbl_t TAG_TBL = build_tag_tbl();
	localparam mem_tbl_t MEM_TBL = build_mem_tbl();

	// request decode
	logic                   req_accept;
	logic                   acc_accept;
	logic                   load_accept;
	logic [BLOCK_NUM_W-1:0] req_block;

	// stage one: access waiting on its row read
	logic                   acc_valid_s1;
	logic [TAG_W-1:0]       tag_s1;
	logic [SET_W-1:0]       set_s1;
	logic [OFFSET_W-1:0]    offset_s1;
	logic [SIZE_W-1:0]      size_s1;
	logic [STAMP_W-1:0]     stamp_s1;
	logic                   s1_fire;

	logic [STAMP_W-1:0]     clock_q;

	// memory data
	logic [WORD_W-1:0]      fill_lo;
	logic [WORD_W-1:0]      fill_hi;
	logic [ROW_W-1:0]       row_rd;
	logic [WAYS-1:0]        valid_rd;
	logic [ROW_W-1:0]       row_wr;
	logic [WAY_W-1:0]       slot;
	lookup_status_t         status;
	logic [WORD_W-1:0]      look_data;

	// result register
	logic                   rsp_valid_q;
	logic [WORD_W-1:0]      read_data_q;
	logic                   hit_q;
	logic                   cross_error_q;
	logic                   rsp_free;

	assign req_accept  = req_valid && !req_stall;
	assign acc_accept  = req_accept && (command == CMD_ACCESS);
	assign load_accept = req_accept && (command == CMD_LOAD);
	assign req_block   = byte_address[ADDR_W-1:OFFSET_W];

	// one access at a time in the row read-modify-write; the result register
	// decouples the response side, so a stalled response only holds stage one
	assign req_stall = acc_valid_s1;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign s1_fire   = acc_valid_s1 && rsp_free;

	salru_backing_mem #(
		.DEPTH (MEM_DEPTH),
		.AW    (MEM_AW)
	) u_backing_mem (
		.clk      (clk),
		.wr_en    (load_accept),
		.wr_addr  (MEM_TBL[mem_word_index]),
		.wr_data  (mem_word_value),
		.rd_en    (acc_accept),
		.rd_addr0 (MEM_TBL[{req_block, 1'b0}]),
		.rd_addr1 (MEM_TBL[{req_block, 1'b1}]),
		.rd_data0 (fill_lo),
		.rd_data1 (fill_hi)
	);

	salru_set_store #(
		.NUM_SETS (NUM_SETS),
		.WAYS     (WAYS),
		.SET_W    (SET_W),
		.WAY_W    (WAY_W),
		.ROW_W    (ROW_W)
	) u_set_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (acc_accept),
		.rd_set   (SET_TBL[req_block]),
		.rd_row   (row_rd),
		.rd_valid (valid_rd),
		.wr_en    (s1_fire),
		.wr_set   (set_s1),
		.wr_way   (slot),
		.wr_row   (row_wr)
	);

	salru_lookup #(
		.WAYS  (WAYS),
		.TAG_W (TAG_W),
		.WAY_W (WAY_W),
		.ROW_W (ROW_W)
	) u_lookup (
		.row_rd    (row_rd),
		.valid     (valid_rd),
		.tag       (tag_s1),
		.offset    (offset_s1),
		.size      (size_s1),
		.fill      ({fill_hi, fill_lo}),
		.stamp     (stamp_s1),
		.row_wr    (row_wr),
		.slot      (slot),
		.status    (status),
		.read_data (look_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_s1 <= 1'b0;
			clock_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (acc_accept) begin
				acc_valid_s1 <= 1'b1;
				clock_q      <= clock_q + STAMP_W'(1);
			end else if (s1_fire) begin
				acc_valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// stage one payload; stamp is the advanced access clock
	always_ff @(posedge clk) begin
		if (acc_accept) begin
			tag_s1    <= TAG_TBL[req_block];
			set_s1    <= SET_TBL[req_block];
			offset_s1 <= byte_address[OFFSET_W-1:0];
			size_s1   <= access_size;
			stamp_s1  <= clock_q + STAMP_W'(1);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			read_data_q   <= look_data;
			hit_q         <= status.hit;
			cross_error_q <= status.cross_error;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign read_data   = read_data_q;
	assign hit         = hit_q;
	assign cross_error = cross_error_q;

endmodule

/* rtl/salru_backing_mem.sv */
// backing word memory: one write port, two registered read ports
module salru_backing_mem import salru_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr0,
	input  logic [AW-1:0]     rd_addr1,
	output logic [WORD_W-1:0] rd_data0,
	output logic [WORD_W-1:0] rd_data1
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data0 <= mem[rd_addr0];
			rd_data1 <= mem[rd_addr1];
		end
	end

endmodule

/* rtl/salru_set_store.sv */
// per-set row memory (tags, stamps, lines) plus valid flops
module salru_set_store import salru_pkg::*; #(
	parameter int NUM_SETS = 2,
	parameter int WAYS     = 2,
	parameter int SET_W    = 1,
	parameter int WAY_W    = 1,
	parameter int ROW_W    = 202
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [SET_W-1:0] rd_set,
	output logic [ROW_W-1:0] rd_row,
	output logic [WAYS-1:0]  rd_valid,
	input  logic             wr_en,
	input  logic [SET_W-1:0] wr_set,
	input  logic [WAY_W-1:0] wr_way,
	input  logic [ROW_W-1:0] wr_row
);

	logic [ROW_W-1:0] mem [NUM_SETS];
	logic [NUM_SETS-1:0][WAYS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_set] <= wr_row;
		end
		if (rd_en) begin
			rd_row   <= mem[rd_set];
			rd_valid <= valid_q[rd_set];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_set][wr_way] <= 1'b1;
		end
	end

endmodule

/* rtl/salru_lookup.sv */
// tag compare, victim choice, row update and byte extraction
module salru_lookup import salru_pkg::*; #(
	parameter int WAYS  = 2,
	parameter int TAG_W = 5,
	parameter int WAY_W = 1,
	parameter int ROW_W = 202
) (
	input  logic [ROW_W-1:0]    row_rd,
	input  logic [WAYS-1:0]     valid,
	input  logic [TAG_W-1:0]    tag,
	input  logic [OFFSET_W-1:0] offset,
	input  logic [SIZE_W-1:0]   size,
	input  logic [LINE_W-1:0]   fill,
	input  logic [STAMP_W-1:0]  stamp,
	output logic [ROW_W-1:0]    row_wr,
	output logic [WAY_W-1:0]    slot,
	output lookup_status_t      status,
	output logic [WORD_W-1:0]   read_data
);

	typedef struct packed {
		logic [WAYS-1:0][TAG_W-1:0]   tags;
		logic [WAYS-1:0][STAMP_W-1:0] stamps;
		logic [WAYS-1:0][LINE_W-1:0]  lines;
	} row_t;

	row_t                row_in;
	row_t                row_out;
	logic                hit_found;
	logic [WAY_W-1:0]    hit_way;
	logic                inv_found;
	logic [WAY_W-1:0]    inv_way;
	logic [WAY_W-1:0]    lru_way;
	logic [STAMP_W-1:0]  best;
	logic [WAY_W-1:0]    slot_way;
	logic [LINE_W-1:0]   line;
	logic [LINE_W-1:0]   shifted;
	logic [BYTE_CNT_W-1:0] nbytes;
	logic [OFFSET_W:0]   end_pos;
	logic                crosses;
	logic [WORD_W-1:0]   picked;

	always_comb begin
		row_in = row_t'(row_rd);

		// lowest matching way
		hit_found = 1'b0;
		hit_way   = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid[w] && row_in.tags[w] == tag) begin
				hit_found = 1'b1;
				hit_way   = WAY_W'(w);
			end
		end

		// highest invalid way
		inv_found = 1'b0;
		inv_way   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!valid[w]) begin
				inv_found = 1'b1;
				inv_way   = WAY_W'(w);
			end
		end

		// oldest stamp, last way wins ties
		best    = row_in.stamps[0];
		lru_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (row_in.stamps[w] <= best) begin
				best    = row_in.stamps[w];
				lru_way = WAY_W'(w);
			end
		end

		slot_way = hit_found ? hit_way : (inv_found ? inv_way : lru_way);
		line     = hit_found ? row_in.lines[hit_way] : fill;

		row_out = row_in;
		row_out.stamps[slot_way] = stamp;
		if (!hit_found) begin
			row_out.tags[slot_way]  = tag;
			row_out.lines[slot_way] = fill;
		end

		shifted = line >> {offset, 3'b000};
		case (size)
			SIZE_BYTE: begin
				nbytes = BYTE_CNT_W'(1);
				picked = {24'd0, shifted[7:0]};
			end
			SIZE_HALF: begin
				nbytes = BYTE_CNT_W'(2);
				picked = {16'd0, shifted[15:0]};
			end
			default: begin
				nbytes = BYTE_CNT_W'(4);
				picked = shifted[WORD_W-1:0];
			end
		endcase
		end_pos = {1'b0, offset} + {1'b0, nbytes};
		crosses = end_pos > (OFFSET_W + 1)'(LINE_BYTES);
	end

	assign row_wr             = row_out;
	assign slot               = slot_way;
	assign status.hit         = hit_found;
	assign status.cross_error = crosses;
	assign read_data          = crosses ? '0 : picked;

endmodule

/* rtl/salru_checker.sv */
// port-level assertions for the set-associative read cache, bound to the top level
module salru_checker import salru_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              command,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input logic [WORD_W-1:0] read_data,
	input logic              hit,
	input logic              cross_error
);

	// stalled response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(hit)
			&& $stable(cross_error))
		else $error("stalled response changed");

	// a block-crossing access returns zero data
	a_cross_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && cross_error |-> read_data == '0)
		else $error("crossing access returned data");

	// an accepted access holds off the next request for its write-back
	a_access_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && command == CMD_ACCESS |=> req_stall)
		else $error("request accepted during access write-back");

	// a new response only follows an access that was in flight
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without an access in flight");

endmodule

bind set_assoc_cache_lru_read salru_checker u_salru_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.command     (command),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.read_data   (read_data),
	.hit         (hit),
	.cross_error (cross_error)
);
